[sv/zrbd_pkg.sv]
// Shared types and constants for the zero-run bit-row decompressor.
`timescale 1ns / 1ps
`default_nettype none

package zrbd_pkg;

    localparam int ROW_W      = 10;
    localparam int CNT_W      = 4;
    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = 64;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    localparam logic [ROW_W-1:0] ROW_BYTES_RST = 10'd512;
    localparam logic [7:0]       FILL_BYTE     = 8'hff;
    localparam logic [7:0]       ZERO_BYTE     = 8'h00;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic start_run;
        logic run_final;
    } t_dp_status;

endpackage

`default_nettype wire

[sv/zero_run_bitrow_decompressor_core.sv]
// A literal byte shows on the output in the cycle after its input beat is taken.
// Runs and fills of n bytes: decoded into run registers, then ceil(n/8) words, one word
// per cycle while the output is free. Throughput: one literal, marker or count byte per
// cycle while the output is free; the single word builder holds the input during a run.
// Reset: synchronous, active low; clears row position, marker flag, output valid,
// and sets the row length to 512 bytes.
`timescale 1ns / 1ps
`default_nettype none

module zero_run_bitrow_decompressor_core #(
    parameter int MAX_ROW_BYTES = 512
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: row length in bytes
    input  wire         i_cfg_we,
    input  wire  [9:0]  i_cfg_wdata,
    // input stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire         i_s_tuser,   // [0] command: 0 data byte, 1 fill row with 0xff
    // output stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [71:0] o_m_tdata,   // [63:0] out_word, [67:64] byte_count, [71:68] zero
    output logic        o_m_tlast    // last_of_row
);

    zrbd_pkg::t_ctrl_cmd  cmd;
    zrbd_pkg::t_dp_status status;

    // Controller: hold the input while a run or fill drains, one word per free
    // output slot; advance back to accepting when the last word is built.
    zrbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    // Datapath: track the position in the row, decode markers and counts,
    // clip zero runs at the row end, and register each output beat. The output
    // register lets a new input beat be taken in the cycle the old one leaves.
    zrbd_dp #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tready  (i_m_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

[sv/zrbd_ctrl.sv]
// Controller: accepts input beats and sequences the emission of multi-word runs.
`timescale 1ns / 1ps
`default_nettype none

module zrbd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    input  zrbd_pkg::t_dp_status i_status,
    output logic                 o_s_tready,
    output zrbd_pkg::t_ctrl_cmd  o_cmd
);

    zrbd_pkg::t_state r_state;
    zrbd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zrbd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_s_tready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            zrbd_pkg::ST_IDLE: begin
                o_s_tready   = i_status.out_free;
                o_cmd.accept = i_s_tvalid && i_status.out_free;
                if (o_cmd.accept && i_status.start_run) begin
                    n_state = zrbd_pkg::ST_RUN;
                end
            end
            zrbd_pkg::ST_RUN: begin
                o_cmd.emit = i_status.out_free;
                if (o_cmd.emit && i_status.run_final) begin
                    n_state = zrbd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = zrbd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/zrbd_dp.sv]
// Datapath: row tracking, run decode, word builder and output register.
`timescale 1ns / 1ps
`default_nettype none

module zrbd_dp #(
    parameter int MAX_ROW_BYTES = 512
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [zrbd_pkg::ROW_W-1:0]         i_cfg_wdata,
    input  wire  [zrbd_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  wire                                i_s_tuser,
    input  wire                                i_m_tready,
    input  zrbd_pkg::t_ctrl_cmd                i_cmd,
    output zrbd_pkg::t_dp_status               o_status,
    output logic                               o_m_tvalid,
    output logic [zrbd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);

    localparam logic [zrbd_pkg::ROW_W-1:0] MaxLen = zrbd_pkg::ROW_W'(MAX_ROW_BYTES);

    // control registers
    logic [zrbd_pkg::ROW_W-1:0] r_row_bytes, n_row_bytes;
    logic [zrbd_pkg::ROW_W-1:0] r_row_pos,   n_row_pos;
    logic                       r_expect,    n_expect;
    logic                       r_out_valid, n_out_valid;

    // run and output payload
    logic [zrbd_pkg::ROW_W-1:0]  r_run_left, n_run_left;
    logic [7:0]                  r_run_byte, n_run_byte;
    logic                        r_run_last, n_run_last;
    logic [zrbd_pkg::WORD_W-1:0] r_out_word, n_out_word;
    logic [zrbd_pkg::CNT_W-1:0]  r_out_cnt,  n_out_cnt;
    logic                        r_out_last, n_out_last;

    logic [zrbd_pkg::ROW_W-1:0] row_len;
    logic [zrbd_pkg::ROW_W-1:0] pos_eff;
    logic [zrbd_pkg::ROW_W-1:0] remaining;
    logic [zrbd_pkg::ROW_W-1:0] data_ext;
    logic                       run_final;
    logic [zrbd_pkg::CNT_W-1:0] step_cnt;
    logic [zrbd_pkg::WORD_W-1:0] step_word;

    always_comb begin
        if (r_row_bytes == '0) begin
            row_len = zrbd_pkg::ROW_W'(1);
        end else if (r_row_bytes > MaxLen) begin
            row_len = MaxLen;
        end else begin
            row_len = r_row_bytes;
        end
        pos_eff   = (r_row_pos >= row_len) ? '0 : r_row_pos;
        remaining = row_len - pos_eff;
        data_ext  = zrbd_pkg::ROW_W'(i_s_tdata);
    end

    // one word of the current run: up to eight copies of the run byte
    always_comb begin
        run_final = (r_run_left <= zrbd_pkg::ROW_W'(zrbd_pkg::WORD_BYTES));
        step_cnt  = run_final ? r_run_left[zrbd_pkg::CNT_W-1:0]
                              : zrbd_pkg::CNT_W'(zrbd_pkg::WORD_BYTES);
        for (int i = 0; i < zrbd_pkg::WORD_BYTES; i++) begin
            step_word[8*i +: 8] = (zrbd_pkg::CNT_W'(i) < step_cnt) ? r_run_byte : 8'h00;
        end
    end

    assign o_status.out_free  = !r_out_valid || i_m_tready;
    assign o_status.run_final = run_final;
    assign o_status.start_run = (i_s_tuser == zrbd_pkg::CMD_FILL)
                             || (r_expect && (i_s_tdata != 8'h00));

    always_comb begin
        n_row_bytes = r_row_bytes;
        n_row_pos   = r_row_pos;
        n_expect    = r_expect;
        n_run_left  = r_run_left;
        n_run_byte  = r_run_byte;
        n_run_last  = r_run_last;
        n_out_word  = r_out_word;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_m_tready;

        if (i_cfg_we) begin
            // a new row length also starts a new row
            n_row_bytes = i_cfg_wdata;
            n_row_pos   = '0;
            n_expect    = 1'b0;
        end else if (i_cmd.accept) begin
            if (i_s_tuser == zrbd_pkg::CMD_FILL) begin
                n_row_pos  = '0;
                n_expect   = 1'b0;
                n_run_left = row_len;
                n_run_byte = zrbd_pkg::FILL_BYTE;
                n_run_last = 1'b1;
            end else if (r_expect) begin
                n_expect  = 1'b0;
                n_row_pos = pos_eff;
                if (i_s_tdata != 8'h00) begin
                    n_run_byte = zrbd_pkg::ZERO_BYTE;
                    // cut the run at the row end
                    if (data_ext >= remaining) begin
                        n_run_left = remaining;
                        n_run_last = 1'b1;
                        n_row_pos  = '0;
                    end else begin
                        n_run_left = data_ext;
                        n_run_last = 1'b0;
                        n_row_pos  = pos_eff + data_ext;
                    end
                end
            end else if (i_s_tdata == 8'h00) begin
                n_expect  = 1'b1;
                n_row_pos = pos_eff;
            end else begin
                // literal byte goes straight to the output register
                n_out_word  = zrbd_pkg::WORD_W'(i_s_tdata);
                n_out_cnt   = zrbd_pkg::CNT_W'(1);
                n_out_valid = 1'b1;
                if (remaining == zrbd_pkg::ROW_W'(1)) begin
                    n_out_last = 1'b1;
                    n_row_pos  = '0;
                end else begin
                    n_out_last = 1'b0;
                    n_row_pos  = pos_eff + zrbd_pkg::ROW_W'(1);
                end
            end
        end

        if (i_cmd.emit) begin
            n_out_word  = step_word;
            n_out_cnt   = step_cnt;
            n_out_last  = r_run_last && run_final;
            n_out_valid = 1'b1;
            n_run_left  = r_run_left - zrbd_pkg::ROW_W'(step_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= zrbd_pkg::ROW_BYTES_RST;
            r_row_pos   <= '0;
            r_expect    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_row_bytes <= n_row_bytes;
            r_row_pos   <= n_row_pos;
            r_expect    <= n_expect;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_left <= n_run_left;
        r_run_byte <= n_run_byte;
        r_run_last <= n_run_last;
        r_out_word <= n_out_word;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(zrbd_pkg::OUT_DATA_W - zrbd_pkg::WORD_W - zrbd_pkg::CNT_W){1'b0}},
                         r_out_cnt, r_out_word};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

[sv/zrbd_checker.sv]
// Port-level checks for the zero-run bit-row decompressor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module zrbd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_tvalid,
    input wire        o_s_tready,
    input wire        i_s_tuser,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [71:0] o_m_tdata,
    input wire        o_m_tlast
);

    // no beat is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // each beat carries one to eight bytes and zero pad bits
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[67:64] != 4'd0) && (o_m_tdata[67:64] <= 4'd8)
                       && (o_m_tdata[71:68] == 4'd0))
        else $error("byte count out of range or pad set");

    // a single-byte beat has all upper bytes clear
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[67:64] == 4'd1)) |-> (o_m_tdata[63:8] == 56'd0))
        else $error("unused bytes not zero");

    // a fill command holds the input for at least the next cycle
    a_fill_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser) |=> !o_s_tready)
        else $error("input taken while a fill drains");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid && $stable(o_m_tdata)
                                        && $stable(o_m_tlast))
        else $error("stalled output beat changed");

endmodule

bind zero_run_bitrow_decompressor_core zrbd_checker u_zrbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[verif/zrbd_checker.sv]
// Scoreboard for the zero-run bit-row decompressor: predicts output words and checks them.
`timescale 1ns / 1ps

module zrbd_scoreboard #(
    parameter int MAX_ROW_BYTES = 512,
    parameter int MAX_REPORTS   = 10
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [zrbd_pkg::ROW_W-1:0]         i_cfg_wdata,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    input  wire  [zrbd_pkg::IN_DATA_W-1:0]     i_s_tdata,   // [7:0] data_byte
    input  wire                                i_s_tuser,   // [0] command
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    // [63:0] out_word, [67:64] byte_count, [71:68] zero
    input  wire  [zrbd_pkg::OUT_DATA_W-1:0]    i_m_tdata,
    input  wire                                i_m_tlast,   // last_of_row
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_beats_in,
    output int                                 o_words_out,
    output int                                 o_rows_out
);

    typedef struct packed {
        logic [zrbd_pkg::WORD_W-1:0] payload;
        logic [zrbd_pkg::CNT_W-1:0]  nbytes;
        logic                        row_end;
    } t_out_word;

    t_out_word                  expected_words[$];
    logic [zrbd_pkg::ROW_W-1:0] row_setting;
    logic [zrbd_pkg::ROW_W-1:0] row_pos;
    logic                       run_pending;

    function automatic int unsigned clamp_row_len(logic [zrbd_pkg::ROW_W-1:0] setting);
        int unsigned n;
        n = setting;
        if (n == 0) n = 1;
        if (n > MAX_ROW_BYTES) n = MAX_ROW_BYTES;
        return n;
    endfunction

    // Split n copies of one byte into words of up to eight bytes.
    task automatic queue_run(int unsigned n, logic [7:0] value, logic ends_row);
        t_out_word   w;
        int unsigned take;
        while (n > 0) begin
            take = (n > zrbd_pkg::WORD_BYTES) ? zrbd_pkg::WORD_BYTES : n;
            w.payload = '0;
            for (int i = 0; i < take; i++) w.payload[8*i +: 8] = value;
            n -= take;
            w.nbytes  = zrbd_pkg::CNT_W'(take);
            w.row_end = (n == 0) ? ends_row : 1'b0;
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_beat(logic cmd, logic [7:0] data);
        int unsigned len;
        int unsigned remaining;
        int unsigned n;
        len = clamp_row_len(row_setting);
        if (cmd == zrbd_pkg::CMD_FILL) begin
            // fill drops any partial row and any pending marker
            row_pos     = '0;
            run_pending = 1'b0;
            queue_run(len, zrbd_pkg::FILL_BYTE, 1'b1);
        end else begin
            if (row_pos >= len) row_pos = '0;
            remaining = len - row_pos;
            if (run_pending) begin
                run_pending = 1'b0;
                n = data;
                if (n != 0 && n >= remaining) begin
                    // cut the run at the row end
                    row_pos = '0;
                    queue_run(remaining, zrbd_pkg::ZERO_BYTE, 1'b1);
                end else if (n != 0) begin
                    row_pos = row_pos + zrbd_pkg::ROW_W'(n);
                    queue_run(n, zrbd_pkg::ZERO_BYTE, 1'b0);
                end
            end else if (data == zrbd_pkg::ZERO_BYTE) begin
                run_pending = 1'b1;
            end else if (remaining == 1) begin
                row_pos = '0;
                queue_run(1, data, 1'b1);
            end else begin
                row_pos = row_pos + 1'b1;
                queue_run(1, data, 1'b0);
            end
        end
    endtask

    task automatic note_failure(string what);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_word();
        t_out_word                   want;
        logic [zrbd_pkg::WORD_W-1:0] got_payload;
        logic [zrbd_pkg::CNT_W-1:0]  got_count;
        logic [zrbd_pkg::OUT_DATA_W-zrbd_pkg::WORD_W-zrbd_pkg::CNT_W-1:0] got_pad;
        got_payload = i_m_tdata[zrbd_pkg::WORD_W-1:0];
        got_count   = i_m_tdata[zrbd_pkg::WORD_W +: zrbd_pkg::CNT_W];
        got_pad     = i_m_tdata[zrbd_pkg::OUT_DATA_W-1:zrbd_pkg::WORD_W+zrbd_pkg::CNT_W];
        o_words_out++;
        if (i_m_tlast) o_rows_out++;
        if (expected_words.size() == 0) begin
            note_failure($sformatf("unexpected word %h count %0d last %b",
                                   got_payload, got_count, i_m_tlast));
        end else begin
            want = expected_words.pop_front();
            if (got_payload !== want.payload || got_count !== want.nbytes ||
                i_m_tlast !== want.row_end || got_pad !== '0)
                note_failure($sformatf(
                    {"word mismatch: expected %h count %0d last %b, ",
                     "got %h count %0d last %b pad %h"},
                    want.payload, want.nbytes, want.row_end,
                    got_payload, got_count, i_m_tlast, got_pad));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            row_setting  = zrbd_pkg::ROW_BYTES_RST;
            row_pos      = '0;
            run_pending  = 1'b0;
            o_fail_count = 0;
            o_beats_in   = 0;
            o_words_out  = 0;
            o_rows_out   = 0;
        end else begin
            if (i_cfg_we) begin
                row_setting = i_cfg_wdata;
                row_pos     = '0;
                run_pending = 1'b0;
            end
            // check before predicting: a word never leaves in the cycle its beat enters
            if (i_m_tvalid && i_m_tready) check_word();
            if (i_s_tvalid && i_s_tready) begin
                o_beats_in++;
                predict_beat(i_s_tuser, i_s_tdata);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

[verif/tb_zero_run_bitrow_decompressor_core.sv]
// Testbench top for the zero-run bit-row decompressor: stimulus, traffic shaping and verdict.
`timescale 1ns / 1ps

module tb_zero_run_bitrow_decompressor_core;

    localparam int HALF_NS       = 5;
    localparam int RST_CYCLES    = 10;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_ROW       = 512;
    localparam int IDLE_PCT      = 74;
    localparam int BOTH_PCT      = 23;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 25;

    typedef enum {
        TR_STEADY,
        TR_SRC_IDLE,
        TR_SINK_STALL,
        TR_BOTH
    } t_traffic;

    // Every input is known from time zero.
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [zrbd_pkg::ROW_W-1:0]       cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic [zrbd_pkg::IN_DATA_W-1:0]   s_tdata   = '0;                 // [7:0] data_byte
    logic                             s_tuser   = zrbd_pkg::CMD_DATA; // [0] command
    logic                             m_tready  = 1'b0;
    wire                              s_tready;
    wire                              m_tvalid;
    // [63:0] out_word, [67:64] byte_count, [71:68] zero
    wire  [zrbd_pkg::OUT_DATA_W-1:0]  m_tdata;
    wire                              m_tlast;   // last_of_row

    int   fails, pending, beats_in, words_out, rows_out;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   settings_used  = 0;
    logic hold_req       = 1'b0;

    always #HALF_NS clk = ~clk;

    zero_run_bitrow_decompressor_core #(
        .MAX_ROW_BYTES(MAX_ROW)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    zrbd_scoreboard #(
        .MAX_ROW_BYTES(MAX_ROW)
    ) u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_fail_count(fails),
        .o_pending   (pending),
        .o_beats_in  (beats_in),
        .o_words_out (words_out),
        .o_rows_out  (rows_out)
    );

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d output words still expected", pending);
        $display("tb_zero_run_bitrow_decompressor_core failed");
        $finish;
    end

    // Receiver: random stalls per the current traffic mode. A hold request
    // drops tready for a long stretch so the block backs up into its input.
    initial begin : sink
        int held;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic set_traffic(t_traffic mode);
        case (mode)
            TR_STEADY: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            TR_SRC_IDLE: begin
                src_idle_pct   = IDLE_PCT;
                sink_stall_pct = 0;
            end
            TR_SINK_STALL: begin
                src_idle_pct   = 0;
                sink_stall_pct = IDLE_PCT;
            end
            default: begin
                src_idle_pct   = BOTH_PCT;
                sink_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    // Offer one beat after a random gap and hold it until taken. Valid stays
    // high into the next beat when there is no gap.
    task automatic send_beat(input logic cmd, input logic [7:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    // Zero marker followed by its run count.
    task automatic send_run(input logic [7:0] count);
        send_beat(zrbd_pkg::CMD_DATA, zrbd_pkg::ZERO_BYTE);
        send_beat(zrbd_pkg::CMD_DATA, count);
    endtask

    // Drop valid and wait until every predicted word has come out, then let the
    // block settle in case a marker or zero count is still in flight.
    task automatic wait_drained();
        int waited;
        @(negedge clk);
        s_tvalid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && pending != 0; waited++) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_row_bytes(input logic [zrbd_pkg::ROW_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // One random item: mostly well-formed rows (literals, marker plus count,
    // the odd fill), the rest raw noise. Reports how many beats it used.
    task automatic send_random_item(input int row_len, output int beats);
        int pick;
        int fill_pct;
        int cap;
        int sel;
        pick     = $urandom_range(0, 99);
        fill_pct = (row_len > 64) ? 2 : 8;
        cap      = (2 * row_len + 1 > 255) ? 255 : 2 * row_len + 1;
        beats    = 1;
        if (pick < 30) begin
            send_beat(($urandom_range(0, 9) == 0) ? zrbd_pkg::CMD_FILL : zrbd_pkg::CMD_DATA,
                      8'($urandom_range(0, 255)));
        end else if (pick < 30 + fill_pct) begin
            send_beat(zrbd_pkg::CMD_FILL, 8'($urandom_range(0, 255)));
        end else if (pick < 65) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)      send_run(8'h00);
            else if (sel == 1) send_run(8'hff);
            else               send_run(8'($urandom_range(1, cap)));
            beats = 2;
        end else begin
            send_beat(zrbd_pkg::CMD_DATA, 8'($urandom_range(1, 255)));
        end
    endtask

    initial begin : stimulus
        int                         ph;
        int                         sent;
        int                         used;
        int                         eff_len;
        logic [zrbd_pkg::ROW_W-1:0] setting;
        logic                       paused;

        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset row length of 512.
        set_traffic(TR_STEADY);
        send_beat(zrbd_pkg::CMD_DATA, 8'h01);
        send_beat(zrbd_pkg::CMD_DATA, 8'hff);
        send_run(8'h00);                                   // zero count emits nothing
        send_run(8'hff);                                   // longest run
        send_beat(zrbd_pkg::CMD_FILL, 8'h5a);              // full 512-byte fill, data ignored
        send_beat(zrbd_pkg::CMD_DATA, zrbd_pkg::ZERO_BYTE); // marker abandoned by the fill below
        send_beat(zrbd_pkg::CMD_FILL, 8'h00);
        send_beat(zrbd_pkg::CMD_DATA, 8'h55);

        // Three-byte rows: end a row on a literal, cut a run at the row end,
        // finish a row exactly on a run, then fill.
        wait_drained();
        write_row_bytes(10'd3);
        send_beat(zrbd_pkg::CMD_DATA, 8'h11);
        send_beat(zrbd_pkg::CMD_DATA, 8'h22);
        send_beat(zrbd_pkg::CMD_DATA, 8'h33);
        send_run(8'd5);
        send_beat(zrbd_pkg::CMD_DATA, 8'h44);
        send_run(8'd2);
        send_beat(zrbd_pkg::CMD_FILL, 8'hff);

        // Row length zero acts as one byte per row.
        wait_drained();
        write_row_bytes(10'd0);
        send_beat(zrbd_pkg::CMD_DATA, 8'h7f);
        send_run(8'd9);
        send_beat(zrbd_pkg::CMD_FILL, 8'h00);

        // Row length above the maximum clamps to 512.
        wait_drained();
        write_row_bytes(10'h3ff);
        send_beat(zrbd_pkg::CMD_DATA, 8'h80);
        send_beat(zrbd_pkg::CMD_FILL, 8'h00);

        // Random phases, each with its own row length and traffic mode.
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       setting = 10'd8;
                1:       setting = 10'd1;
                2:       setting = zrbd_pkg::ROW_W'($urandom_range(2, 40));
                3:       setting = 10'd512;
                4:       setting = 10'd17;
                5:       setting = zrbd_pkg::ROW_W'($urandom_range(1, 1023));
                6:       setting = 10'd9;
                default: setting = 10'd3;
            endcase
            write_row_bytes(setting);
            eff_len = (setting == 0) ? 1 : ((setting > MAX_ROW) ? MAX_ROW : setting);
            set_traffic(t_traffic'(ph % 4));

            // Back-to-back input against a long receiver hold: fill the block up.
            if (ph == 0) hold_req = 1'b1;

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_BEATS) begin
                // Halfway through one phase, stop sending until the output has drained.
                if (ph == 4 && !paused && sent >= PHASE_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_random_item(eff_len, used);
                sent += used;
            end
        end

        wait_drained();
        if (pending != 0)
            $display("%0d expected output words never arrived", pending);
        $display("Covered %0d input beats, %0d output words and %0d row ends",
                 beats_in, words_out, rows_out);
        $display("over %0d row lengths with steady, idle-sender, stalled-receiver and mixed traffic.",
                 settings_used + 1);
        if (fails == 0 && pending == 0) begin
            $display("tb_zero_run_bitrow_decompressor_core passed");
        end else begin
            $display("tb_zero_run_bitrow_decompressor_core failed");
        end
        $finish;
    end

endmodule
